[sv/image_header_sniffer_assert.svh]
// Assertion macros shared by the sniffer RTL.
// IHS_ASSERT_IMPLIES: consequent must hold in the same cycle.
// IHS_ASSERT_NEXT:    consequent must hold one cycle later.
`ifndef IMAGE_HEADER_SNIFFER_ASSERT_SVH
`define IMAGE_HEADER_SNIFFER_ASSERT_SVH

`ifndef SYNTHESIS
`define IHS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define IHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define IHS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define IHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/ihs_pkg.sv]
`timescale 1ns / 1ps

package ihs_pkg;

    // Default width of the byte position counter
    localparam int POSITION_BITS_DEF = 32;

    // Result format codes
    typedef enum logic [2:0] {
        FMT_PNG     = 3'd0,
        FMT_JPEG    = 3'd1,
        FMT_GIF     = 3'd2,
        FMT_BMP     = 3'd3,
        FMT_TIFF    = 3'd4,
        FMT_EMF     = 3'd5,
        FMT_WMF     = 3'd6,
        FMT_UNKNOWN = 3'd7
    } fmt_t;

    // JPEG segment walk phases
    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_MARKER = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_FRAME  = 3'd4,
        PH_STOP   = 3'd5
    } walk_phase_t;

    // Magic numbers, first file byte in the low byte
    localparam logic [63:0] PNG_MAGIC     = 64'h0A1A_0A0D_474E_5089;
    localparam logic [23:0] JPEG_MAGIC    = 24'hFF_D8FF;
    localparam logic [31:0] GIF_MAGIC     = 32'h3846_4947;
    localparam logic [15:0] BMP_MAGIC     = 16'h4D42;
    localparam logic [31:0] TIFF_LE_MAGIC = 32'h002A_4949;
    localparam logic [31:0] TIFF_BE_MAGIC = 32'h2A00_4D4D;
    localparam logic [31:0] EMF_MAGIC     = 32'h0000_0001;
    localparam logic [31:0] WMF_MAGIC     = 32'h9AC6_CDD7;

    // JPEG marker bytes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;
    localparam logic [7:0] MARK_SOF2   = 8'hC2;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_SOS    = 8'hDA;

    // Byte-lane writes from the JPEG walker into the dimension registers
    typedef struct packed {
        logic wr_height_hi;
        logic wr_height_lo;
        logic wr_width_hi;
        logic wr_width_lo;
        logic frame_found;
    } jpeg_cap_t;

    // Replace one byte lane of a 32-bit word
    function automatic logic [31:0] set_lane(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  data);
        logic [31:0] res;
        res = word;
        unique case (lane)
            2'd0: res[7:0]   = data;
            2'd1: res[15:8]  = data;
            2'd2: res[23:16] = data;
            2'd3: res[31:24] = data;
            default: res = word;
        endcase
        return res;
    endfunction

endpackage

[sv/ihs_classify.sv]
`timescale 1ns / 1ps

// Magic-number classifier over the leading eight bytes
module ihs_classify
    import ihs_pkg::*;
(
    input  logic [63:0] lead_bytes,   // byte k in bits 8k+7:8k
    input  logic [3:0]  avail,        // bytes present, 0..8
    output fmt_t        fmt
);

    logic is_png, is_jpeg, is_gif, is_bmp, is_tiff, is_emf, is_wmf;

    // A magic longer than the file never matches
    assign is_png  = (avail >= 4'd8) && (lead_bytes == PNG_MAGIC);
    assign is_jpeg = (avail >= 4'd3) && (lead_bytes[23:0] == JPEG_MAGIC);
    assign is_gif  = (avail >= 4'd4) && (lead_bytes[31:0] == GIF_MAGIC);
    assign is_bmp  = (avail >= 4'd2) && (lead_bytes[15:0] == BMP_MAGIC);
    assign is_tiff = (avail >= 4'd4) && ((lead_bytes[31:0] == TIFF_LE_MAGIC) ||
                                         (lead_bytes[31:0] == TIFF_BE_MAGIC));
    assign is_emf  = (avail >= 4'd4) && (lead_bytes[31:0] == EMF_MAGIC);
    assign is_wmf  = (avail >= 4'd4) && (lead_bytes[31:0] == WMF_MAGIC);

    // Test order decides
    always_comb begin
        priority if (is_png) begin
            fmt = FMT_PNG;
        end else if (is_jpeg) begin
            fmt = FMT_JPEG;
        end else if (is_gif) begin
            fmt = FMT_GIF;
        end else if (is_bmp) begin
            fmt = FMT_BMP;
        end else if (is_tiff) begin
            fmt = FMT_TIFF;
        end else if (is_emf) begin
            fmt = FMT_EMF;
        end else if (is_wmf) begin
            fmt = FMT_WMF;
        end else begin
            fmt = FMT_UNKNOWN;
        end
    end

endmodule

[sv/ihs_jpeg_walk.sv]
`timescale 1ns / 1ps
`include "image_header_sniffer_assert.svh"

// JPEG marker segment walker: one byte per step
module ihs_jpeg_walk
    import ihs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,       // a word is processed
    input  logic                     clear,      // last word of the file
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [7:0]               data_byte,
    input  logic                     soi_seen,   // bytes 0,1 are FF D8
    output jpeg_cap_t                cap
);

    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [POSITION_BITS-1:0] SEG_FIRST = POSITION_BITS'(2);

    walk_phase_t              phase_reg, phase_next;
    logic [POSITION_BITS-1:0] seg_start_reg, seg_start_next;
    logic [7:0]               len_hi_reg, len_hi_next;
    logic                     frame_found_reg, frame_found_next;

    logic [POSITION_BITS:0]   diff;
    logic                     before_seg;
    logic [POSITION_BITS-1:0] seg_off;
    logic [15:0]              seg_len;
    logic [POSITION_BITS:0]   seg_sum;
    logic [POSITION_BITS-1:0] seg_after;
    logic                     is_jpeg;
    logic                     stopped;

    // Offset into the current segment
    assign diff       = {1'b0, pos} - {1'b0, seg_start_reg};
    assign before_seg = diff[POSITION_BITS];
    assign seg_off    = diff[POSITION_BITS-1:0];

    // Start of the following segment, clamped at the top
    assign seg_len   = {len_hi_reg, data_byte};
    assign seg_sum   = {1'b0, seg_start_reg} + (POSITION_BITS + 1)'(seg_len)
                       + (POSITION_BITS + 1)'(2);
    assign seg_after = seg_sum[POSITION_BITS] ? POS_MAX : seg_sum[POSITION_BITS-1:0];

    // Only the first segment checks the start-of-image bytes
    assign is_jpeg = (pos != SEG_FIRST) || soi_seen;

    // Next walk state and lane writes
    always_comb begin
        phase_next       = phase_reg;
        seg_start_next   = seg_start_reg;
        len_hi_next      = len_hi_reg;
        frame_found_next = frame_found_reg;
        cap              = '0;
        if (step) begin
            priority if (phase_reg == PH_STOP) begin
                phase_next = PH_STOP;
            end else if (pos == POS_MAX) begin
                phase_next = PH_STOP;
            end else if (!before_seg) begin
                unique case (phase_reg)
                    PH_PREFIX: begin
                        if (seg_off == '0) begin
                            phase_next = (data_byte == MARK_PREFIX && is_jpeg) ?
                                         PH_MARKER : PH_STOP;
                        end
                    end
                    PH_MARKER: begin
                        if (seg_off == POSITION_BITS'(1)) begin
                            priority if (data_byte == MARK_SOF0 ||
                                         data_byte == MARK_SOF2) begin
                                phase_next = PH_FRAME;
                            end else if (data_byte == MARK_EOI ||
                                         data_byte == MARK_SOS) begin
                                phase_next = PH_STOP;
                            end else begin
                                phase_next = PH_LEN_HI;
                            end
                        end
                    end
                    PH_LEN_HI: begin
                        if (seg_off == POSITION_BITS'(2)) begin
                            len_hi_next = data_byte;
                            phase_next  = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO: begin
                        if (seg_off == POSITION_BITS'(3)) begin
                            if (seg_len < 16'd2) begin
                                phase_next = PH_STOP;
                            end else begin
                                seg_start_next = seg_after;
                                phase_next     = PH_PREFIX;
                            end
                        end
                    end
                    PH_FRAME: begin
                        // height at segment offsets 5,6; width at 7,8
                        priority if (seg_off == POSITION_BITS'(5)) begin
                            cap.wr_height_hi = 1'b1;
                        end else if (seg_off == POSITION_BITS'(6)) begin
                            cap.wr_height_lo = 1'b1;
                        end else if (seg_off == POSITION_BITS'(7)) begin
                            cap.wr_width_hi = 1'b1;
                        end else if (seg_off == POSITION_BITS'(8)) begin
                            cap.wr_width_lo = 1'b1;
                        end else if (seg_off == POSITION_BITS'(9)) begin
                            frame_found_next = 1'b1;
                            phase_next       = PH_STOP;
                        end else begin
                            phase_next = PH_FRAME;
                        end
                    end
                    default: phase_next = PH_STOP;
                endcase
            end else begin
                phase_next = phase_reg;
            end
        end
        cap.frame_found = frame_found_next;
    end

    // Walk state; restarts after the last word of each file
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && clear)) begin
            phase_reg       <= PH_PREFIX;
            seg_start_reg   <= SEG_FIRST;
            len_hi_reg      <= '0;
            frame_found_reg <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            seg_start_reg   <= seg_start_next;
            len_hi_reg      <= len_hi_next;
            frame_found_reg <= frame_found_next;
        end
    end

    assign stopped = phase_reg == PH_STOP;

    `IHS_ASSERT_IMPLIES(a_frame_ends_walk, aclk, aresetn, frame_found_reg, stopped)
    `IHS_ASSERT_NEXT(a_stop_sticks, aclk, aresetn, stopped && !(step && clear), stopped)
    `IHS_ASSERT_IMPLIES(a_seg_start_min, aclk, aresetn, 1'b1, seg_start_reg >= SEG_FIRST)

endmodule

[sv/image_header_sniffer.sv]
`timescale 1ns / 1ps
`include "image_header_sniffer_assert.svh"

// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  s_data_byte, s_last_byte
// m_        out        m_valid / m_ready  m_format_code, m_image_width, m_image_height
//
// One byte per cycle unless a held result stalls a last byte: a byte first
// waits in the input register, then the header state updates and, on the last
// byte, the result register loads.
// aresetn is synchronous, active low; it clears all control and header state.
// A held result stalls only a following last byte; other bytes keep flowing.
module image_header_sniffer
    import ihs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_last_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_format_code,
    output logic signed [31:0] m_image_width,
    output logic signed [31:0] m_image_height
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;

    // Header state
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [63:0]              lead_reg, lead_next;
    logic [31:0]              first_reg, first_next, first_hdr;
    logic [31:0]              second_reg, second_next, second_hdr;

    // Result register
    logic               out_valid_reg;
    fmt_t               fmt_reg;
    logic signed [31:0] width_reg;
    logic signed [31:0] height_reg;

    logic        pos_lt8, pos_lt32;
    logic [4:0]  off;
    logic [3:0]  avail;
    logic        gif_hdr, png_hdr, bmp_hdr, soi_seen;
    logic        wr_first, wr_second;
    logic [1:0]  hdr_lane;
    fmt_t        fmt;
    jpeg_cap_t   cap;
    logic [31:0] res_w, res_h;
    logic        load_out, no_dims_out, bmp_out;

    // Move on unless a last word would overwrite a waiting result
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // Leading bytes including the current one
    assign pos_lt8  = pos_reg < POSITION_BITS'(8);
    assign pos_lt32 = pos_reg < POSITION_BITS'(32);
    assign off      = pos_reg[4:0];
    assign avail    = pos_lt8 ? ({1'b0, pos_reg[2:0]} + 4'd1) : 4'd8;

    always_comb begin
        lead_next = lead_reg;
        for (int k = 0; k < 8; k++) begin
            if (pos_lt8 && pos_reg[2:0] == 3'(k)) begin
                lead_next[8*k +: 8] = lead_reg[8*k +: 8] | in_byte_reg;
            end
        end
    end

    ihs_classify u_classify (
        .lead_bytes (lead_next),
        .avail      (avail),
        .fmt        (fmt)
    );

    // Header bytes already stored when their dimension fields arrive
    assign gif_hdr  = lead_reg[31:0] == GIF_MAGIC;
    assign png_hdr  = lead_reg == PNG_MAGIC;
    assign bmp_hdr  = lead_reg[15:0] == BMP_MAGIC;
    assign soi_seen = lead_reg[15:0] == {MARK_SOI, MARK_PREFIX};

    // Fixed-offset dimension fields: GIF 6..9, PNG 16..23, BMP 18..25
    always_comb begin
        wr_first  = 1'b0;
        wr_second = 1'b0;
        hdr_lane  = 2'd0;
        priority if (pos_lt32 && gif_hdr && off >= 5'd6 && off <= 5'd9) begin
            wr_first  = off < 5'd8;
            wr_second = !(off < 5'd8);
            hdr_lane  = {1'b0, off[0]};
        end else if (pos_lt32 && png_hdr && off >= 5'd16 && off <= 5'd23) begin
            wr_first  = off < 5'd20;
            wr_second = !(off < 5'd20);
            hdr_lane  = ~off[1:0];
        end else if (pos_lt32 && bmp_hdr && off >= 5'd18 && off <= 5'd25) begin
            wr_first  = off < 5'd22;
            wr_second = !(off < 5'd22);
            hdr_lane  = off[1:0] - 2'd2;
        end else begin
            wr_first  = 1'b0;
        end
    end

    ihs_jpeg_walk #(
        .POSITION_BITS (POSITION_BITS)
    ) u_jpeg_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .clear     (in_last_reg),
        .pos       (pos_reg),
        .data_byte (in_byte_reg),
        .soi_seen  (soi_seen),
        .cap       (cap)
    );

    // Dimension registers with this word's lane writes applied
    always_comb begin
        first_hdr  = wr_first ? set_lane(first_reg, hdr_lane, in_byte_reg) : first_reg;
        second_hdr = wr_second ? set_lane(second_reg, hdr_lane, in_byte_reg) : second_reg;
        first_next  = first_hdr;
        second_next = second_hdr;
        if (cap.wr_width_hi) begin
            first_next[15:8] = in_byte_reg;
        end
        if (cap.wr_width_lo) begin
            first_next[7:0] = in_byte_reg;
        end
        if (cap.wr_height_hi) begin
            second_next[15:8] = in_byte_reg;
        end
        if (cap.wr_height_lo) begin
            second_next[7:0] = in_byte_reg;
        end
    end

    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POSITION_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            pos_reg    <= '0;
            lead_reg   <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end else if (advance) begin
            pos_reg    <= pos_next;
            lead_reg   <= lead_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Result dimensions for the detected format
    always_comb begin
        res_w = '0;
        res_h = '0;
        unique case (fmt)
            FMT_PNG: begin
                if (pos_reg >= POSITION_BITS'(23)) begin
                    res_w = first_next;
                    res_h = second_next;
                end
            end
            FMT_GIF: begin
                if (pos_reg >= POSITION_BITS'(9)) begin
                    res_w = {16'd0, first_next[15:0]};
                    res_h = {16'd0, second_next[15:0]};
                end
            end
            FMT_BMP: begin
                if (pos_reg >= POSITION_BITS'(25)) begin
                    res_w = first_next;
                    // absolute height, most negative saturates
                    if (second_next == 32'h8000_0000) begin
                        res_h = 32'h7FFF_FFFF;
                    end else if (second_next[31]) begin
                        res_h = 32'd0 - second_next;
                    end else begin
                        res_h = second_next;
                    end
                end
            end
            FMT_JPEG: begin
                if (cap.frame_found) begin
                    res_w = {16'd0, first_next[15:0]};
                    res_h = {16'd0, second_next[15:0]};
                end
            end
            default: begin
                res_w = '0;
                res_h = '0;
            end
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            fmt_reg    <= fmt;
            width_reg  <= res_w;
            height_reg <= res_h;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_format_code  = fmt_reg;
    assign m_image_width  = width_reg;
    assign m_image_height = height_reg;

    // Terms for the checks below
    assign load_out    = advance && in_last_reg;
    assign no_dims_out = out_valid_reg && (fmt_reg == FMT_TIFF || fmt_reg == FMT_EMF ||
                                           fmt_reg == FMT_WMF || fmt_reg == FMT_UNKNOWN);
    assign bmp_out     = out_valid_reg && fmt_reg == FMT_BMP;

    `IHS_ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, out_valid_reg && !m_ready, !load_out)
    `IHS_ASSERT_NEXT(a_pos_restart, aclk, aresetn, load_out, pos_reg == '0)
    `IHS_ASSERT_IMPLIES(a_no_dims, aclk, aresetn, no_dims_out, width_reg == '0 && height_reg == '0)
    `IHS_ASSERT_IMPLIES(a_bmp_height_pos, aclk, aresetn, bmp_out, !height_reg[31])

endmodule
